@@ hw/rtl/cnsk_pkg.sv @@
// Shared constants, codes and reciprocal tables for the cable neck servo kinematics block.
// No dependencies; imported by the sine/cosine pipeline, the top level, the checker and the testbench.
package cnsk_pkg;

  localparam int unsigned AngleFracBitsDefault = 12;

  // Taylor series depth and the latency of the sine/cosine pipeline
  localparam int unsigned TaylorTerms   = 7;
  localparam int unsigned SinCosStages  = 2 + 2 * TaylorTerms + 1;

  localparam logic [29:0] InvTwoPiQ32   = 30'd683565276;
  localparam logic [30:0] HalfPiQ30     = 31'd1686629713;
  localparam logic [31:0] Recip3        = 32'hAAAA_AAAB;
  localparam logic [21:0] NineOverPiQ20 = 22'd3003949;
  localparam logic [29:0] RadToDegQ24   = 30'd961263669;
  localparam logic [30:0] OneQ30        = 31'd1073741824;

  localparam logic [7:0]  FrameEnd      = 8'd181;
  localparam logic [7:0]  ServoMax      = 8'd180;

  // Exact division of a 32-bit value by a small constant: (x * M) >> S
  localparam logic [32:0] SinRecip [TaylorTerms] = '{
    33'(((64'd1 << 35) + 64'd5)   / 64'd6),
    33'(((64'd1 << 37) + 64'd19)  / 64'd20),
    33'(((64'd1 << 38) + 64'd41)  / 64'd42),
    33'(((64'd1 << 39) + 64'd71)  / 64'd72),
    33'(((64'd1 << 39) + 64'd109) / 64'd110),
    33'(((64'd1 << 40) + 64'd155) / 64'd156),
    33'(((64'd1 << 40) + 64'd209) / 64'd210)
  };
  localparam int unsigned SinShift [TaylorTerms] = '{35, 37, 38, 39, 39, 40, 40};

  localparam logic [32:0] CosRecip [TaylorTerms] = '{
    33'(((64'd1 << 33) + 64'd1)   / 64'd2),
    33'(((64'd1 << 36) + 64'd11)  / 64'd12),
    33'(((64'd1 << 37) + 64'd29)  / 64'd30),
    33'(((64'd1 << 38) + 64'd55)  / 64'd56),
    33'(((64'd1 << 39) + 64'd89)  / 64'd90),
    33'(((64'd1 << 40) + 64'd131) / 64'd132),
    33'(((64'd1 << 40) + 64'd181) / 64'd182)
  };
  localparam int unsigned CosShift [TaylorTerms] = '{33, 36, 37, 38, 39, 40, 40};

  // Position of a byte in the servo frame
  typedef enum logic [2:0] {
    SlotLeft, SlotRight, SlotFront, SlotBack, SlotYaw, SlotEnd
  } slot_e;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CfgLeft, CfgRight, CfgFront, CfgBack, CfgYaw
  } cfg_idx_e;

  typedef struct packed {
    logic               valid;
    logic signed [25:0] sin_v;
    logic signed [25:0] cos_v;
  } trig_t;

endpackage

@@ hw/rtl/cnsk_sincos.sv @@
// Pipelined sine and cosine of a Q32-turn phase, Q24 results, seven Taylor terms.
// Depends on cnsk_pkg (reciprocal tables, stage count, trig_t).
module cnsk_sincos (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  logic [31:0]   phase_i,
  output cnsk_pkg::trig_t trig_o
);
  import cnsk_pkg::*;

  logic [SinCosStages-1:0] vld_q;

  // stage 1: phase to Q30 radians
  logic [60:0] r_prod;
  logic [30:0] r1_q;
  logic [1:0]  quad1_q;
  assign r_prod = 61'(phase_i[29:0]) * 61'(HalfPiQ30);

  // per-term stage registers; index 0 holds the series start
  logic        [31:0] ts_q   [TaylorTerms+1];
  logic        [31:0] tc_q   [TaylorTerms+1];
  logic signed [33:0] s_q    [TaylorTerms+1];
  logic signed [33:0] c_q    [TaylorTerms+1];
  logic        [31:0] r2_q   [TaylorTerms+1];
  logic        [1:0]  quad_q [TaylorTerms+1];

  logic        [31:0] pts_q  [TaylorTerms];
  logic        [31:0] ptc_q  [TaylorTerms];
  logic signed [33:0] as_q   [TaylorTerms];
  logic signed [33:0] ac_q   [TaylorTerms];
  logic        [31:0] ar2_q  [TaylorTerms];
  logic        [1:0]  aquad_q[TaylorTerms];

  logic [61:0] r2_prod;
  assign r2_prod = 62'(r1_q) * 62'(r1_q);

  // advance valid bits with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[SinCosStages-2:0], valid_i};
    end
  end

  // stages 1 and 2: angle and its square
  always_ff @(posedge clk_i) begin
    r1_q      <= r_prod[60:30];
    quad1_q   <= phase_i[31:30];
    r2_q[0]   <= r2_prod[61:30];
    ts_q[0]   <= 32'(r1_q);
    tc_q[0]   <= 32'(OneQ30);
    s_q[0]    <= $signed(34'(r1_q));
    c_q[0]    <= $signed(34'(OneQ30));
    quad_q[0] <= quad1_q;
  end

  // two stages per term: multiply by r^2, then divide by the factor pair
  for (genvar g = 0; g < TaylorTerms; g++) begin : g_term
    logic [64:0] sprod;
    logic [64:0] cprod;
    logic [31:0] ts_new;
    logic [31:0] tc_new;

    always_ff @(posedge clk_i) begin
      pts_q[g]   <= 32'((64'(ts_q[g]) * 64'(r2_q[g])) >> 30);
      ptc_q[g]   <= 32'((64'(tc_q[g]) * 64'(r2_q[g])) >> 30);
      as_q[g]    <= s_q[g];
      ac_q[g]    <= c_q[g];
      ar2_q[g]   <= r2_q[g];
      aquad_q[g] <= quad_q[g];
    end

    assign sprod  = 65'(pts_q[g]) * 65'(SinRecip[g]);
    assign cprod  = 65'(ptc_q[g]) * 65'(CosRecip[g]);
    assign ts_new = 32'(sprod >> SinShift[g]);
    assign tc_new = 32'(cprod >> CosShift[g]);

    always_ff @(posedge clk_i) begin
      ts_q[g+1]   <= ts_new;
      tc_q[g+1]   <= tc_new;
      r2_q[g+1]   <= ar2_q[g];
      quad_q[g+1] <= aquad_q[g];
      if ((g % 2) == 0) begin
        s_q[g+1] <= as_q[g] - $signed({2'b00, ts_new});
        c_q[g+1] <= ac_q[g] - $signed({2'b00, tc_new});
      end else begin
        s_q[g+1] <= as_q[g] + $signed({2'b00, ts_new});
        c_q[g+1] <= ac_q[g] + $signed({2'b00, tc_new});
      end
    end
  end

  // final stage: clamp, place in quadrant, drop to Q24 toward zero
  logic [30:0]        s_cl, c_cl, sin_mag, cos_mag;
  logic               sin_neg, cos_neg;
  logic signed [25:0] sin_d, cos_d, sin_q, cos_q;

  always_comb begin
    if (s_q[TaylorTerms] < 0) begin
      s_cl = '0;
    end else if (s_q[TaylorTerms] > $signed(34'(OneQ30))) begin
      s_cl = OneQ30;
    end else begin
      s_cl = s_q[TaylorTerms][30:0];
    end
    if (c_q[TaylorTerms] < 0) begin
      c_cl = '0;
    end else if (c_q[TaylorTerms] > $signed(34'(OneQ30))) begin
      c_cl = OneQ30;
    end else begin
      c_cl = c_q[TaylorTerms][30:0];
    end
    case (quad_q[TaylorTerms])
      2'd0: begin
        sin_mag = s_cl; sin_neg = 1'b0; cos_mag = c_cl; cos_neg = 1'b0;
      end
      2'd1: begin
        sin_mag = c_cl; sin_neg = 1'b0; cos_mag = s_cl; cos_neg = 1'b1;
      end
      2'd2: begin
        sin_mag = s_cl; sin_neg = 1'b1; cos_mag = c_cl; cos_neg = 1'b1;
      end
      default: begin
        sin_mag = c_cl; sin_neg = 1'b1; cos_mag = s_cl; cos_neg = 1'b0;
      end
    endcase
    sin_d = sin_neg ? -$signed({1'b0, sin_mag[30:6]}) : $signed({1'b0, sin_mag[30:6]});
    cos_d = cos_neg ? -$signed({1'b0, cos_mag[30:6]}) : $signed({1'b0, cos_mag[30:6]});
  end

  always_ff @(posedge clk_i) begin
    sin_q <= sin_d;
    cos_q <= cos_d;
  end

  assign trig_o.valid = vld_q[SinCosStages-1];
  assign trig_o.sin_v = sin_q;
  assign trig_o.cos_v = cos_q;

endmodule

@@ hw/rtl/cable_neck_servo_kinematics_top.sv @@
// An accepted pose runs through the angle stages, both sine/cosine pipelines and the
// four cable stages; its frame then strobes out one byte per cycle. busy_o holds off new
// starts for one six-byte frame on the single result port, with older poses in flight.
// Reset clears valid bits, the frame sequencer and the neutral angles to their defaults.
// Results cannot be held off by the receiver.
// Depends on cnsk_pkg and cnsk_sincos.
module cable_neck_servo_kinematics_top #(
  parameter int unsigned ANGLE_FRACTION_BITS = cnsk_pkg::AngleFracBitsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [12:0]        tilt_rad_i,
  input  logic [14:0]        pan_rad_i,
  input  logic signed [14:0] yaw_rad_i,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [7:0]         cfg_data_i,
  output logic               strobe_o,
  output logic [7:0]         servo_byte_o,
  output logic [2:0]         frame_slot_o,
  output logic               last_of_frame_o
);
  import cnsk_pkg::*;

  localparam int unsigned YawShift = ANGLE_FRACTION_BITS + 24;

  function automatic logic [7:0] sat_deg(input logic signed [63:0] total,
                                         input int unsigned shift);
    logic signed [63:0] deg;
    begin
      deg = total >>> shift;
      if (total <= 0) begin
        return 8'd0;
      end else if (deg > $signed(64'(ServoMax))) begin
        return ServoMax;
      end else begin
        return deg[7:0];
      end
    end
  endfunction

  // configuration registers
  logic [7:0] neut_q [5];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      neut_q[CfgLeft]  <= 8'd115;
      neut_q[CfgRight] <= 8'd120;
      neut_q[CfgFront] <= 8'd115;
      neut_q[CfgBack]  <= 8'd130;
      neut_q[CfgYaw]   <= 8'd90;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgLeft:  neut_q[CfgLeft]  <= cfg_data_i;
        CfgRight: neut_q[CfgRight] <= cfg_data_i;
        CfgFront: neut_q[CfgFront] <= cfg_data_i;
        CfgBack:  neut_q[CfgBack]  <= cfg_data_i;
        CfgYaw:   neut_q[CfgYaw]   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // pace starts one frame apart
  logic       accept;
  logic [2:0] gap_q;
  assign accept = start_i & ~busy_o;
  assign busy_o = (gap_q != 3'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_q <= '0;
    end else if (accept) begin
      gap_q <= 3'd5;
    end else if (gap_q != 3'd0) begin
      gap_q <= gap_q - 3'd1;
    end
  end

  // stage 1: angle products and yaw sum
  logic                v1_q, v2_q;
  logic [42:0]         tilt_prod_q;
  logic [31:0]         pan_ph1_q, pan_ph2_q, tilt_ph2_q;
  logic signed [63:0]  yaw_tot_q;
  logic [7:0]          yaw2_q;
  logic [44:0]         pan_prod;
  logic [31:0]         tilt_div;
  logic [63:0]         tilt_rec;

  assign pan_prod = 45'(pan_rad_i) * 45'(InvTwoPiQ32);
  assign tilt_div = 32'(tilt_prod_q >> (ANGLE_FRACTION_BITS + 1));
  assign tilt_rec = 64'(tilt_div) * 64'(Recip3);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= accept;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    tilt_prod_q <= 43'(tilt_rad_i) * 43'(InvTwoPiQ32);
    pan_ph1_q   <= 32'(pan_prod >> ANGLE_FRACTION_BITS);
    yaw_tot_q   <= 64'(yaw_rad_i) * $signed(64'(RadToDegQ24))
                 + $signed(64'(neut_q[CfgYaw]) << YawShift);
    // stage 2: tilt / 6 and yaw saturation
    tilt_ph2_q  <= 32'(tilt_rec >> 33);
    pan_ph2_q   <= pan_ph1_q;
    yaw2_q      <= sat_deg(yaw_tot_q, YawShift);
  end

  // sine and cosine of tilt/6 and pan
  trig_t tilt_tr, pan_tr;

  cnsk_sincos u_tilt_sc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v2_q),
    .phase_i (tilt_ph2_q),
    .trig_o  (tilt_tr)
  );

  cnsk_sincos u_pan_sc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v2_q),
    .phase_i (pan_ph2_q),
    .trig_o  (pan_tr)
  );

  // hold yaw byte alongside the trig pipeline
  logic [7:0] yaw_dly_q [SinCosStages];
  always_ff @(posedge clk_i) begin
    yaw_dly_q[0] <= yaw2_q;
    for (int i = 1; i < SinCosStages; i++) begin
      yaw_dly_q[i] <= yaw_dly_q[i-1];
    end
  end

  // cable stages: product, numerator, scale, add neutral
  logic signed [25:0] kc [4];
  assign kc[2'(SlotLeft)]  = pan_tr.cos_v;
  assign kc[2'(SlotRight)] = -pan_tr.cos_v;
  assign kc[2'(SlotFront)] = -pan_tr.sin_v;
  assign kc[2'(SlotBack)]  = pan_tr.sin_v;

  logic               c1v_q, c2v_q, c3v_q, c4v_q;
  logic signed [51:0] p_q   [4];
  logic signed [39:0] base_q;
  logic signed [43:0] qt_q  [4];
  logic signed [63:0] off_q [4];
  logic [7:0]         byte_q[4];
  logic [7:0]         yc1_q, yc2_q, yc3_q, yc4_q;
  logic signed [63:0] num   [4];
  logic signed [63:0] numr  [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      num[i]  = (64'(base_q) <<< 24) - 64'sd240 * 64'(p_q[i]);
      numr[i] = (num[i] < 0) ? num[i] + 64'sd1048575 : num[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1v_q <= 1'b0;
      c2v_q <= 1'b0;
      c3v_q <= 1'b0;
      c4v_q <= 1'b0;
    end else begin
      c1v_q <= tilt_tr.valid;
      c2v_q <= c1v_q;
      c3v_q <= c2v_q;
      c4v_q <= c3v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q <= 40'sd540 * (40'(tilt_tr.cos_v) - 40'sd16777216)
            - 40'sd60 * 40'(tilt_tr.sin_v);
    yc1_q  <= yaw_dly_q[SinCosStages-1];
    yc2_q  <= yc1_q;
    yc3_q  <= yc2_q;
    yc4_q  <= yc3_q;
    for (int i = 0; i < 4; i++) begin
      p_q[i]    <= 52'(kc[i]) * 52'(tilt_tr.sin_v);
      qt_q[i]   <= 44'(numr[i] >>> 20);
      off_q[i]  <= 64'(qt_q[i]) * $signed(64'(NineOverPiQ20));
      byte_q[i] <= sat_deg($signed(64'(neut_q[i]) << 48) + off_q[i], 48);
    end
  end

  // frame sequencer: load a frame, step through six slots
  logic       act_q;
  slot_e      slot_q;
  logic [7:0] fr_q [5];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q  <= 1'b0;
      slot_q <= SlotLeft;
    end else if (c4v_q) begin
      act_q  <= 1'b1;
      slot_q <= SlotLeft;
    end else if (act_q) begin
      if (slot_q == SlotEnd) begin
        act_q <= 1'b0;
      end else begin
        slot_q <= slot_e'(slot_q + 3'd1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (c4v_q) begin
      for (int i = 0; i < 4; i++) begin
        fr_q[i] <= byte_q[i];
      end
      fr_q[SlotYaw] <= yc4_q;
    end
  end

  always_comb begin
    case (slot_q)
      SlotLeft:  servo_byte_o = fr_q[SlotLeft];
      SlotRight: servo_byte_o = fr_q[SlotRight];
      SlotFront: servo_byte_o = fr_q[SlotFront];
      SlotBack:  servo_byte_o = fr_q[SlotBack];
      SlotYaw:   servo_byte_o = fr_q[SlotYaw];
      default:   servo_byte_o = FrameEnd;
    endcase
  end

  assign strobe_o        = act_q;
  assign frame_slot_o    = slot_q;
  assign last_of_frame_o = act_q & (slot_q == SlotEnd);

endmodule

@@ hw/rtl/cnsk_checker.sv @@
// Port-level checks on pacing and frame order of the cable neck servo kinematics block.
// Depends on cnsk_pkg; bound to cable_neck_servo_kinematics_top.
module cnsk_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start_i,
  input logic               busy_o,
  input logic               strobe_o,
  input logic [7:0]         servo_byte_o,
  input logic [2:0]         frame_slot_o,
  input logic               last_of_frame_o
);
  import cnsk_pkg::*;

  // a start beat blocks the next start
  a_pace: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("start taken while a frame interval was open");

  // terminator closes the frame
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_of_frame_o |-> (strobe_o && frame_slot_o == SlotEnd && servo_byte_o == FrameEnd))
    else $error("terminator beat malformed");

  // slots advance one per cycle inside a frame
  a_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && frame_slot_o != SlotEnd) |=>
      (strobe_o && frame_slot_o == 3'($past(frame_slot_o) + 3'd1)))
    else $error("frame slot sequence broken");

  // servo bytes stay in range
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && frame_slot_o != SlotEnd) |-> (servo_byte_o <= ServoMax && !last_of_frame_o))
    else $error("servo byte out of range");

endmodule

bind cable_neck_servo_kinematics_top cnsk_checker u_cnsk_checker (.*);

@@ sim/cable_neck_servo_kinematics_top_tb.sv @@
// Self-checking testbench for cable_neck_servo_kinematics_top: poses in, six-byte servo frames out.
// Depends on cnsk_pkg and the RTL of the block; a small scoreboard predicts every frame byte.
module cable_neck_servo_kinematics_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cnsk_pkg::*;

  localparam int unsigned FracBits    = AngleFracBitsDefault;
  localparam int unsigned IdleLimit   = 2000;
  localparam int unsigned DrainCycles = 40;
  // index past the last register; writes there must be dropped
  localparam logic [2:0]  CfgUnused   = 3'd7;

  typedef struct {
    logic [7:0] servo;
    slot_e      slot;
    logic       last;
  } frame_byte_t;

  // Predicts servo frames from poses and the neutral angles; checks each byte in order.
  class servo_frame_board;
    logic [7:0]  neutral [5];
    frame_byte_t pending [$];
    int          errors;

    function new();
      errors = 0;
      restore_defaults();
    endfunction

    function void restore_defaults();
      neutral[CfgLeft]  = 8'd115;
      neutral[CfgRight] = 8'd120;
      neutral[CfgFront] = 8'd115;
      neutral[CfgBack]  = 8'd130;
      neutral[CfgYaw]   = 8'd90;
    endfunction

    function void write_reg(logic [2:0] idx, logic [7:0] value);
      if (idx <= CfgYaw) neutral[idx] = value;
    endfunction

    task report(string what);
      $display("%0t mismatch: %s", $realtime, what);
      errors++;
    endtask

    // sine and cosine of a Q32-turn phase in Q24
    function automatic void sin_cos(input logic [31:0] phase, output longint s24,
                                    output longint c24);
      longint unsigned low, r, r2, ts, tc;
      longint          s, c, rs, rc;
      low = longint'(phase[29:0]);
      r   = (low * 64'd1686629713) >> 30;
      r2  = (r * r) >> 30;
      ts  = r;
      tc  = 64'd1073741824;
      s   = longint'(r);
      c   = 64'sd1073741824;
      for (int k = 1; k <= 7; k++) begin
        ts = ((ts * r2) >> 30) / longint'((2 * k) * (2 * k + 1));
        tc = ((tc * r2) >> 30) / longint'((2 * k - 1) * (2 * k));
        if (k % 2 == 1) begin
          s -= longint'(ts);
          c -= longint'(tc);
        end else begin
          s += longint'(ts);
          c += longint'(tc);
        end
      end
      if (s < 0) s = 0;
      if (s > 64'sd1073741824) s = 64'sd1073741824;
      if (c < 0) c = 0;
      if (c > 64'sd1073741824) c = 64'sd1073741824;
      case (phase[31:30])
        2'd0:    begin rs = s;  rc = c;  end
        2'd1:    begin rs = c;  rc = -s; end
        2'd2:    begin rs = -s; rc = -c; end
        default: begin rs = -c; rc = s;  end
      endcase
      s24 = rs / 64;
      c24 = rc / 64;
    endfunction

    function automatic logic [7:0] clamp_deg(longint total, int shift);
      longint deg;
      if (total <= 0) return 8'd0;
      deg = total >>> shift;
      return (deg > 180) ? ServoMax : 8'(deg);
    endfunction

    function automatic logic [7:0] cable_deg(longint k24, longint ct, longint st,
                                             logic [7:0] base);
      longint one, x, num, off;
      one = 64'sd16777216;
      x   = 20 * k24 + 5 * one;
      num = 540 * ct * one - 12 * x * st - 540 * one * one;
      off = (num / 64'sd1048576) * 64'sd3003949;
      return clamp_deg((longint'(base) <<< 48) + off, 48);
    endfunction

    function void push(logic [7:0] servo, slot_e slot);
      frame_byte_t b;
      b.servo = servo;
      b.slot  = slot;
      b.last  = (slot == SlotEnd);
      pending.insert(pending.size(), b);
    endfunction

    // expand one accepted pose into its frame
    function void note_pose(logic [12:0] tilt, logic [14:0] pan, logic signed [14:0] yaw);
      longint unsigned tp, pp;
      longint          st, ct, sp, cp, ytot;
      tp = (longint'(tilt) * 64'd683565276) / (64'd6 << FracBits);
      pp = (longint'(pan) * 64'd683565276) >> FracBits;
      sin_cos(tp[31:0], st, ct);
      sin_cos(pp[31:0], sp, cp);
      push(cable_deg(cp, ct, st, neutral[CfgLeft]), SlotLeft);
      push(cable_deg(-cp, ct, st, neutral[CfgRight]), SlotRight);
      push(cable_deg(-sp, ct, st, neutral[CfgFront]), SlotFront);
      push(cable_deg(sp, ct, st, neutral[CfgBack]), SlotBack);
      ytot = longint'(yaw) * 64'sd961263669 + (longint'(neutral[CfgYaw]) <<< (FracBits + 24));
      push(clamp_deg(ytot, FracBits + 24), SlotYaw);
      push(FrameEnd, SlotEnd);
    endfunction

    task check_byte(logic [7:0] servo, logic [2:0] slot, logic last);
      frame_byte_t e;
      if (pending.size() == 0) begin
        report($sformatf("unexpected beat slot %0d byte %0d", slot, servo));
        return;
      end
      e = pending.pop_front();
      if (slot !== e.slot)
        report($sformatf("slot got %0d want %0d", slot, e.slot));
      if (servo !== e.servo)
        report($sformatf("slot %0d byte got %0d want %0d", e.slot, servo, e.servo));
      if (last !== e.last)
        report($sformatf("slot %0d last got %b want %b", e.slot, last, e.last));
    endtask
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic               busy_o;
  logic [12:0]        tilt_rad_i = '0;
  logic [14:0]        pan_rad_i = '0;
  logic signed [14:0] yaw_rad_i = '0;
  logic               cfg_we_i = 1'b0;
  logic [2:0]         cfg_idx_i = '0;
  logic [7:0]         cfg_data_i = '0;
  logic               strobe_o;
  logic [7:0]         servo_byte_o;
  logic [2:0]         frame_slot_o;
  logic               last_of_frame_o;

  servo_frame_board board = new();
  int unsigned      idle_cycles = 0;
  int               burst_left = 0;

  cable_neck_servo_kinematics_top #(.ANGLE_FRACTION_BITS(FracBits)) i_dut (.*);

  always #5 clk_i = ~clk_i;

  // check every frame byte at the edge that accepts it
  always @(posedge clk_i) begin
    if (rst_ni && strobe_o) board.check_byte(servo_byte_o, frame_slot_o, last_of_frame_o);
  end

  // end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (strobe_o || (start_i && !busy_o) || cfg_we_i || !rst_ni) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IdleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic write_cfg(logic [2:0] idx, logic [7:0] value);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = value;
    @(posedge clk_i);
    board.write_reg(idx, value);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // hold start until the block takes the pose; insert burst gaps first
  task automatic send_pose(logic [12:0] tilt, logic [14:0] pan, logic signed [14:0] yaw);
    bit taken;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      if ($urandom_range(0, 2) != 0) begin
        start_i = 1'b0;
        repeat ($urandom_range(1, 15)) @(negedge clk_i);
      end
    end
    burst_left--;
    start_i    = 1'b1;
    tilt_rad_i = tilt;
    pan_rad_i  = pan;
    yaw_rad_i  = yaw;
    do begin
      taken = !busy_o;
      @(posedge clk_i);
      @(negedge clk_i);
    end while (!taken);
    board.note_pose(tilt, pan, yaw);
  endtask

  task automatic drain();
    @(negedge clk_i);
    start_i = 1'b0;
    while (board.pending.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic random_poses(int count);
    for (int n = 0; n < count; n++) begin
      case ($urandom_range(0, 3))
        0: send_pose(13'($urandom), 15'($urandom), 15'($urandom));
        default: send_pose(13'($urandom_range(0, 6434)), 15'($urandom_range(0, 25736)),
                           15'(int'($urandom_range(0, 25736)) - 12868));
      endcase
    end
  endtask

  task automatic write_all(logic [7:0] value);
    for (int i = CfgLeft; i <= CfgYaw; i++) write_cfg(3'(i), value);
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: field extremes, quadrant edges, yaw limits, all at reset neutrals
    send_pose(13'd0, 15'd0, 15'sd0);
    send_pose(13'd6434, 15'd0, 15'sd12868);
    send_pose(13'd6434, 15'd6434, -15'sd12868);
    send_pose(13'd6434, 15'd12868, 15'sd0);
    send_pose(13'd6434, 15'd19302, 15'sd0);
    send_pose(13'd6434, 15'd25736, 15'sd1);
    send_pose(13'd8191, 15'd32767, 15'sd16383);
    send_pose(13'd8191, 15'd3217, -15'sd16384);
    send_pose(13'd3217, 15'd9651, -15'sd1);
    send_pose(13'd1, 15'd1, 15'sd1);
    send_pose(13'd5000, 15'd16000, 15'sd6000);
    send_pose(13'd8191, 15'd0, 15'sd0);
    random_poses(30);
    drain();

    // saturate low: every neutral at zero
    write_all(8'd0);
    send_pose(13'd0, 15'd0, -15'sd12868);
    send_pose(13'd6434, 15'd6434, 15'sd12868);
    random_poses(30);
    drain();

    // saturate high: neutrals at 180, then at 255 (above the servo range)
    write_all(ServoMax);
    send_pose(13'd0, 15'd0, 15'sd12868);
    random_poses(30);
    drain();
    write_all(8'hFF);
    send_pose(13'd0, 15'd0, -15'sd16384);
    random_poses(30);
    drain();

    // random neutrals, plus a write to an unused index that must be dropped
    for (int i = CfgLeft; i <= CfgYaw; i++) write_cfg(3'(i), 8'($urandom_range(0, 180)));
    write_cfg(CfgUnused, 8'($urandom));
    random_poses(35);
    drain();

    // back to reset values through the port, then a final random stretch
    write_cfg(CfgLeft, 8'd115);
    write_cfg(CfgRight, 8'd120);
    write_cfg(CfgFront, 8'd115);
    write_cfg(CfgBack, 8'd130);
    write_cfg(CfgYaw, 8'd90);
    random_poses(35);
    drain();

    if (board.errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/cnsk_pkg.sv
hw/rtl/cnsk_sincos.sv
hw/rtl/cable_neck_servo_kinematics_top.sv
hw/rtl/cnsk_checker.sv
sim/cable_neck_servo_kinematics_top_tb.sv
